>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_RUN(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/dclm_pkg.sv
// Shared constants, types and helper functions of the command line matcher.
package dclm_pkg;

    localparam int LINE_BYTES      = 64;
    localparam int COMMAND_SLOTS   = 4;
    localparam int COMMAND_CHARS   = 8;
    localparam int DELIMITER_CHARS = 2;

    localparam int FILL_W  = $clog2(LINE_BYTES + 1);
    localparam int PTR_W   = $clog2(LINE_BYTES);
    localparam int HEAD_W  = $clog2(COMMAND_CHARS);
    localparam int CLEN_W  = 4;
    localparam int CHUNK_W = 7;
    localparam int SLOT_W  = 2;
    localparam int SUM_W   = ((FILL_W > CHUNK_W) ? FILL_W : CHUNK_W) + 1;

    // Configuration register indexes.
    localparam logic [2:0] REG_TEXT_A  = 3'd0;
    localparam logic [2:0] REG_TEXT_B  = 3'd1;
    localparam logic [2:0] REG_TEXT_C  = 3'd2;
    localparam logic [2:0] REG_TEXT_D  = 3'd3;
    localparam logic [2:0] REG_LENGTHS = 3'd4;
    localparam logic [2:0] REG_COUNT   = 3'd5;
    localparam logic [2:0] REG_DELIM   = 3'd6;
    localparam logic [2:0] REG_DLEN    = 3'd7;

    // Controller to datapath commands.
    typedef struct packed {
        logic store;
        logic match;
        logic fetch;
        logic advance;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic line_end;
        logic found;
        logic arg_empty;
        logic last_out;
    } t_dp_status;

    // Delimiter length in use: zero counts as one, larger values are capped.
    function automatic logic [1:0] eff_dlen(input logic [1:0] raw);
        logic [1:0] d;
        d = (raw == 2'd0) ? 2'd1 : raw;
        if (d > 2'(DELIMITER_CHARS)) d = 2'(DELIMITER_CHARS);
        return d;
    endfunction

    // Number of commands in use: zero counts as one, larger values are capped.
    function automatic logic [2:0] eff_ncmd(input logic [2:0] raw);
        logic [2:0] n;
        n = (raw == 3'd0) ? 3'd1 : raw;
        if (n > 3'(COMMAND_SLOTS)) n = 3'(COMMAND_SLOTS);
        return n;
    endfunction

endpackage

>>> rtl/dclm_ctrl.sv
// Controller state machine of the command line matcher.
module dclm_ctrl
    import dclm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MATCH = 4'b0010,
        S_FETCH = 4'b0100,
        S_SEND  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state selection.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_status.line_end) n_state = S_MATCH;
            end
            S_MATCH: begin
                if (!i_status.found) n_state = S_IDLE;
                else if (i_status.arg_empty) n_state = S_SEND;
                else n_state = S_FETCH;
            end
            S_FETCH: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_out_ready) n_state = i_status.last_out ? S_IDLE : S_FETCH;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Handshakes and datapath commands.
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_SEND);

    always_comb begin
        o_cmd.store   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.match   = (r_state == S_MATCH);
        o_cmd.fetch   = (r_state == S_FETCH);
        o_cmd.advance = (r_state == S_SEND) && i_out_ready;
    end

endmodule

>>> rtl/dclm_dp.sv
// Datapath of the command line matcher: settings, line memory and match logic.
module dclm_dp
    import dclm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_wdata,
    input  logic [7:0]         i_data_byte,
    input  logic               i_chunk_start,
    input  logic [CHUNK_W-1:0] i_chunk_length,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    output logic [SLOT_W-1:0]  o_command_index,
    output logic [7:0]         o_argument_byte,
    output logic               o_argument_valid
);

    // Settings registers.
    logic [63:0] r_cmd_text [COMMAND_SLOTS];
    logic [15:0] r_cmd_len;
    logic [2:0]  r_cmd_cnt;
    logic [15:0] r_delim;
    logic [1:0]  r_delim_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < COMMAND_SLOTS; s++) r_cmd_text[s] <= '0;
            r_cmd_len   <= '0;
            r_cmd_cnt   <= 3'd1;
            r_delim     <= 16'd10;
            r_delim_len <= 2'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TEXT_A:  r_cmd_text[0] <= i_cfg_wdata;
                REG_TEXT_B:  r_cmd_text[1] <= i_cfg_wdata;
                REG_TEXT_C:  r_cmd_text[2] <= i_cfg_wdata;
                REG_TEXT_D:  r_cmd_text[3] <= i_cfg_wdata;
                REG_LENGTHS: r_cmd_len     <= i_cfg_wdata[15:0];
                REG_COUNT:   r_cmd_cnt     <= i_cfg_wdata[2:0];
                REG_DELIM:   r_delim       <= i_cfg_wdata[15:0];
                REG_DLEN:    r_delim_len   <= i_cfg_wdata[1:0];
                default:     r_delim_len   <= r_delim_len;
            endcase
        end
    end

    logic [FILL_W-1:0] r_fill;
    logic [7:0]        r_prev;
    logic [7:0]        r_head [COMMAND_CHARS];
    logic [7:0]        r_mem  [LINE_BYTES];
    logic [7:0]        r_rd_data;
    logic [PTR_W-1:0]  r_ptr;
    logic [FILL_W-1:0] r_remain;
    logic [SLOT_W-1:0] r_cmd_idx;
    logic              r_empty;

    // Fill position for the incoming byte, after an overflowing chunk clears the line.
    logic [SUM_W-1:0]  w_sum;
    logic [FILL_W-1:0] w_fill_eff;
    logic              w_store_ok;
    logic [1:0]        w_dlen;
    logic              w_line_end;

    assign w_sum      = SUM_W'(r_fill) + SUM_W'(i_chunk_length);
    assign w_fill_eff = (i_chunk_start && (w_sum > SUM_W'(LINE_BYTES))) ? '0 : r_fill;
    assign w_store_ok = (w_fill_eff < FILL_W'(LINE_BYTES));
    assign w_dlen     = eff_dlen(r_delim_len);

    // Tail compare against the delimiter; the previous stored byte serves the
    // two-character case.
    always_comb begin
        if (!w_store_ok) begin
            w_line_end = 1'b0;
        end else if (w_dlen == 2'd1) begin
            w_line_end = (i_data_byte == r_delim[7:0]);
        end else begin
            w_line_end = (w_fill_eff != '0) && (r_prev == r_delim[7:0])
                         && (i_data_byte == r_delim[15:8]);
        end
    end

    // Line memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && w_store_ok) begin
            r_mem[w_fill_eff[PTR_W-1:0]] <= i_data_byte;
        end
        if (i_cmd.fetch) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

    // Copies of the leading bytes and of the last byte for the compares.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && w_store_ok) begin
            r_prev <= i_data_byte;
            if (w_fill_eff < FILL_W'(COMMAND_CHARS)) begin
                r_head[w_fill_eff[HEAD_W-1:0]] <= i_data_byte;
            end
        end
    end

    // Per-command prefix compare, then the first hit in table order.
    logic [CLEN_W-1:0] w_cmp  [COMMAND_SLOTS];
    logic              w_hit  [COMMAND_SLOTS];
    logic [2:0]        w_ncmd;
    logic              w_found;
    logic [SLOT_W-1:0] w_sel;
    logic [CLEN_W-1:0] w_sel_cmp;
    logic [SUM_W-1:0]  w_need;
    logic [FILL_W-1:0] w_arg_len;

    assign w_ncmd = eff_ncmd(r_cmd_cnt);

    always_comb begin
        logic [CLEN_W-1:0] clen;
        for (int s = 0; s < COMMAND_SLOTS; s++) begin
            clen = r_cmd_len[s*CLEN_W +: CLEN_W];
            if (clen > CLEN_W'(COMMAND_CHARS)) clen = CLEN_W'(COMMAND_CHARS);
            w_cmp[s] = (FILL_W'(clen) < r_fill) ? clen : CLEN_W'(r_fill);
            w_hit[s] = (3'(s) < w_ncmd);
            for (int k = 0; k < COMMAND_CHARS; k++) begin
                if ((CLEN_W'(k) < w_cmp[s]) && (r_head[k] != r_cmd_text[s][k*8 +: 8])) begin
                    w_hit[s] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        w_found   = 1'b0;
        w_sel     = '0;
        w_sel_cmp = '0;
        for (int s = COMMAND_SLOTS - 1; s >= 0; s--) begin
            if (w_hit[s]) begin
                w_found   = 1'b1;
                w_sel     = SLOT_W'(s);
                w_sel_cmp = w_cmp[s];
            end
        end
    end

    // Argument length, clamped at zero when the command reaches into the delimiter.
    assign w_need    = SUM_W'(w_sel_cmp) + SUM_W'(w_dlen);
    assign w_arg_len = (SUM_W'(r_fill) >= w_need) ? FILL_W'(SUM_W'(r_fill) - w_need) : '0;

    // Fill count: advances on each stored byte, empties once a line is matched.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.match) begin
            r_fill <= '0;
        end else if (i_cmd.store) begin
            r_fill <= w_store_ok ? w_fill_eff + FILL_W'(1) : w_fill_eff;
        end
    end

    // Argument walk: read pointer, bytes left, selected command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain <= '0;
            r_empty  <= 1'b0;
        end else if (i_cmd.match) begin
            r_remain <= w_arg_len;
            r_empty  <= (w_arg_len == '0);
        end else if (i_cmd.advance) begin
            r_remain <= r_remain - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            r_ptr     <= PTR_W'(w_sel_cmp);
            r_cmd_idx <= w_sel;
        end else if (i_cmd.advance) begin
            r_ptr <= r_ptr + PTR_W'(1);
        end
    end

    // Status and result fields.
    assign o_status.line_end  = w_line_end;
    assign o_status.found     = w_found;
    assign o_status.arg_empty = (w_arg_len == '0);
    assign o_status.last_out  = r_empty || (r_remain == FILL_W'(1));

    assign o_command_index  = r_cmd_idx;
    assign o_argument_byte  = r_empty ? 8'd0 : r_rd_data;
    assign o_argument_valid = !r_empty;

endmodule

>>> rtl/delimited_command_line_matcher_top.sv
// Throughput: one received byte per cycle while no line is being reported.
// An ended line holds input off through a match step, then a line memory read and a send
// per argument byte, or just a send for an empty argument, plus output stalls.
// Reset is synchronous, active low: the line empties and settings take their reset values.
// Top level of the delimited command line matcher.
module delimited_command_line_matcher_top
    import dclm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    // Received bytes.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // data_byte[7:0], chunk_start[8], chunk_length[15:9]
    // Command results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // argument_byte[7:0]
    output logic [2:0]  m_axis_tuser,   // command_index[1:0], argument_valid[2]
    output logic        m_axis_tlast
);

    t_dp_cmd           w_cmd;
    t_dp_status        w_status;
    logic [SLOT_W-1:0] w_command_index;
    logic              w_argument_valid;

    dclm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    dclm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_data_byte      (s_axis_tdata[7:0]),
        .i_chunk_start    (s_axis_tdata[8]),
        .i_chunk_length   (s_axis_tdata[15:9]),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_command_index  (w_command_index),
        .o_argument_byte  (m_axis_tdata),
        .o_argument_valid (w_argument_valid)
    );

    assign m_axis_tuser = {w_argument_valid, w_command_index};
    assign m_axis_tlast = w_status.last_out;

endmodule

>>> rtl/dclm_checker.sv
// Port-level checks of the command line matcher and their binding to the top level.
`include "assert_macros.svh"

module dclm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // Input is held off for as long as a result is offered.
    `ASSERT_RUN(a_busy_while_sending, i_clk, i_rst_n, m_axis_tvalid |-> !s_axis_tready, "input taken while a result is pending")

    // An empty argument is always a single, final result with a zero byte.
    `ASSERT_RUN(a_empty_is_last, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tuser[2]) |-> (m_axis_tlast && (m_axis_tdata == 8'd0)), "empty argument not a lone final result")

    // After reset no result is offered.
    `ASSERT_ALL(a_reset_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid, "result offered right after reset")

    // A stalled result stays offered.
    `ASSERT_RUN(a_stall_holds, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result withdrawn while stalled")

    // A stalled result keeps its fields.
    `ASSERT_RUN(a_stall_stable, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)), "result changed while stalled")

endmodule

bind delimited_command_line_matcher_top dclm_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/sv/tb.sv
// Self-checking testbench of the command line matcher: predicts every result from the bytes sent.
`timescale 1ns / 100ps

module tb
    import dclm_pkg::*;
();

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int RANDOM_ITEMS  = 200;
    localparam int RANDOM_PHASES = 6;
    localparam int SETTLE_CYCLES = 12;
    localparam int REPORT_LINES  = 100;

    // One expected result of a matched line.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] arg;
        logic       arg_ok;
        logic       last;
    } t_arg_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // data_byte[7:0], chunk_start[8], chunk_length[15:9]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [7:0]  m_axis_tdata;         // argument_byte[7:0]
    logic [2:0]  m_axis_tuser;         // command_index[1:0], argument_valid[2]
    logic        m_axis_tlast;

    // Predictor copy of the settings and the line.
    logic [63:0] cmd_text_cfg [4];
    logic [15:0] cmd_len_cfg;
    logic [2:0]  cmd_count_cfg;
    logic [15:0] delim_cfg;
    logic [1:0]  delim_len_cfg;
    logic [7:0]  line_buf [LINE_BYTES];
    int          line_fill;

    t_arg_result expected_args [$];
    int          mismatch_count = 0;
    int          sent_items = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          idle_enable = 1'b1;

    delimited_command_line_matcher_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_LINES) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Effective settings: out-of-range values are clamped as the block does.
    function automatic int active_delim_len();
        int d;
        d = (delim_len_cfg == 2'd0) ? 1 : int'(delim_len_cfg);
        return (d > DELIMITER_CHARS) ? DELIMITER_CHARS : d;
    endfunction

    function automatic int active_cmd_count();
        int n;
        n = (cmd_count_cfg == 3'd0) ? 1 : int'(cmd_count_cfg);
        return (n > COMMAND_SLOTS) ? COMMAND_SLOTS : n;
    endfunction

    function automatic int active_cmd_len(input int slot);
        int c;
        c = int'(cmd_len_cfg[slot*4 +: 4]);
        return (c > COMMAND_CHARS) ? COMMAND_CHARS : c;
    endfunction

    task automatic reset_model();
        for (int s = 0; s < 4; s++) cmd_text_cfg[s] = '0;
        cmd_len_cfg   = '0;
        cmd_count_cfg = 3'd1;
        delim_cfg     = 16'd10;
        delim_len_cfg = 2'd1;
        line_fill     = 0;
    endtask

    // Store one byte in the predicted line; on a line end, queue the argument run.
    task automatic track_line_byte(input logic [7:0] b, input logic st, input logic [6:0] clen);
        int dl;
        int cl;
        int cmp;
        int alen;
        bit hit;
        t_arg_result r;
        if (st && (line_fill + int'(clen)) > LINE_BYTES) line_fill = 0;
        if (line_fill >= LINE_BYTES) return;
        line_buf[line_fill] = b;
        line_fill++;
        dl = active_delim_len();
        if (line_fill < dl) return;
        for (int k = 0; k < dl; k++) begin
            if (line_buf[line_fill - dl + k] != delim_cfg[k*8 +: 8]) return;
        end
        // The first command whose leading characters agree with the line wins.
        for (int slot = 0; slot < active_cmd_count(); slot++) begin
            cl  = active_cmd_len(slot);
            cmp = (cl < line_fill) ? cl : line_fill;
            hit = 1'b1;
            for (int k = 0; k < cmp; k++) begin
                if (line_buf[k] != cmd_text_cfg[slot][k*8 +: 8]) hit = 1'b0;
            end
            if (hit) begin
                alen = (line_fill >= cmp + dl) ? line_fill - cmp - dl : 0;
                r.cmd = 2'(slot);
                if (alen == 0) begin
                    r.arg    = 8'h00;
                    r.arg_ok = 1'b0;
                    r.last   = 1'b1;
                    expected_args.push_back(r);
                end else begin
                    for (int k = 0; k < alen; k++) begin
                        r.arg    = line_buf[cmp + k];
                        r.arg_ok = 1'b1;
                        r.last   = (k == alen - 1);
                        expected_args.push_back(r);
                    end
                end
                break;
            end
        end
        line_fill = 0;
    endtask

    // Offer one byte request, after an optional gap, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic st, input logic [6:0] clen);
        if (idle_enable && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {clen, st, b};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_items++;
        track_line_byte(b, st, clen);
    endtask

    // Send a text as one chunk, announced by its own length.
    task automatic send_string(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_byte(s[k], k == 0, (k == 0) ? 7'(s.len()) : 7'd0);
        end
    endtask

    // Let the block finish: every result in, then its latency.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_args.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The write enable stays high between writes of one batch.
    task automatic write_one(input logic [2:0] idx, input logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            REG_TEXT_A:  cmd_text_cfg[0] = value;
            REG_TEXT_B:  cmd_text_cfg[1] = value;
            REG_TEXT_C:  cmd_text_cfg[2] = value;
            REG_TEXT_D:  cmd_text_cfg[3] = value;
            REG_LENGTHS: cmd_len_cfg     = value[15:0];
            REG_COUNT:   cmd_count_cfg   = value[2:0];
            REG_DELIM:   delim_cfg       = value[15:0];
            default:     delim_len_cfg   = value[1:0];
        endcase
    endtask

    task automatic write_all_settings(input logic [63:0] ta, input logic [63:0] tb_text,
                                      input logic [63:0] tc, input logic [63:0] td,
                                      input logic [15:0] lens, input logic [2:0] cnt,
                                      input logic [15:0] dchars, input logic [1:0] dlen);
        write_one(REG_TEXT_A, ta);
        write_one(REG_TEXT_B, tb_text);
        write_one(REG_TEXT_C, tc);
        write_one(REG_TEXT_D, td);
        write_one(REG_LENGTHS, 64'(lens));
        write_one(REG_COUNT, 64'(cnt));
        write_one(REG_DELIM, 64'(dchars));
        write_one(REG_DLEN, 64'(dlen));
        i_cfg_we <= 1'b0;
    endtask

    // Reset settings: one empty command that takes every newline-ended line.
    task automatic test_reset_defaults();
        send_string("ab\n");
        send_string("\n");
        send_string("xyz");
        send_byte("q", 1'b1, 7'd64);
        send_byte("\n", 1'b0, 7'd0);
        drain_results();
    endtask

    // Four commands, a two-byte delimiter, a zero byte in a command, and a
    // command that runs into the delimiter.
    task automatic test_command_table();
        write_all_settings(64'h0000_0000_0074_6573, 64'h0000_0000_000D_6F67,
                           64'h0000_0000_0077_0072, 64'h3736_3534_3332_3130,
                           16'h8333, 3'd4, 16'h0A0D, 2'd2);
        send_string("set5\r\n");
        send_string("set\r\n");
        send_string("go\r\n");
        send_byte("r", 1'b1, 7'd6);
        send_byte(8'h00, 1'b0, 7'd0);
        send_byte("w", 1'b0, 7'd0);
        send_byte("Z", 1'b0, 7'd0);
        send_byte(8'h0D, 1'b0, 7'd0);
        send_byte(8'h0A, 1'b0, 7'd0);
        send_string("01234567!\r\n");
        send_string("nope\r\n");
        drain_results();
    endtask

    // Clamped lengths and counts, zero-byte delimiters, lines shorter than a command.
    task automatic test_range_limits();
        write_all_settings('1, '0, '0, '0, 16'hFFFF, 3'd0, 16'hFF00, 2'd0);
        for (int k = 0; k < 8; k++) send_byte(8'hFF, k == 0, 7'd10);
        send_byte("k", 1'b0, 7'd0);
        send_byte(8'h00, 1'b0, 7'd0);
        send_byte(8'hFF, 1'b1, 7'd2);
        send_byte(8'h00, 1'b0, 7'd0);
        drain_results();

        write_all_settings(64'h61, 64'h62, 64'h63, 64'h3736_3534_3332_3130,
                           16'h9111, 3'd7, 16'h0000, 2'd3);
        send_string("01234567z");
        send_byte(8'h00, 1'b0, 7'd0);
        send_byte(8'h00, 1'b0, 7'd0);
        send_string("bxy");
        send_byte(8'h00, 1'b0, 7'd0);
        send_byte(8'h00, 1'b0, 7'd0);
        send_byte(8'h00, 1'b1, 7'd2);
        send_byte(8'h00, 1'b0, 7'd0);
        drain_results();

        write_all_settings('1, '0, '0, '0, 16'h000F, 3'd1, 16'h00FF, 2'd1);
        send_byte(8'hFF, 1'b1, 7'd1);
        drain_results();
    endtask

    // Longest argument run, then a full store that drops bytes until a chunk clears it.
    task automatic test_store_full();
        logic [7:0] b;
        write_all_settings('0, '0, '0, '0, 16'h0000, 3'd1, 16'h000A, 2'd1);
        for (int k = 0; k < LINE_BYTES - 1; k++) begin
            b = 8'($urandom_range(0, 255));
            if (b == 8'h0A) b = 8'h0B;
            send_byte(b, k == 0, 7'd64);
        end
        send_byte(8'h0A, 1'b0, 7'd0);
        for (int k = 0; k < LINE_BYTES + 2; k++) send_byte("B", k == 0, 7'd64);
        send_byte(8'h0A, 1'b0, 7'd0);
        send_byte("C", 1'b1, 7'd0);
        send_byte("D", 1'b1, 7'd1);
        send_byte(8'h0A, 1'b0, 7'd0);
        drain_results();
    endtask

    // A line built from a command's text, random argument bytes and the delimiter;
    // a broken line has one bit of its command text flipped.
    task automatic send_command_line(input int slot, input int alen, input bit broken);
        logic [7:0] bytes_q [$];
        int         cl;
        int         pos;
        cl = active_cmd_len(slot);
        for (int k = 0; k < cl; k++) bytes_q.push_back(cmd_text_cfg[slot][k*8 +: 8]);
        if (broken && cl > 0) begin
            pos = $urandom_range(0, cl - 1);
            bytes_q[pos] = bytes_q[pos] ^ 8'(1 << $urandom_range(0, 7));
        end
        for (int k = 0; k < alen; k++) bytes_q.push_back(8'($urandom_range(0, 255)));
        for (int k = 0; k < active_delim_len(); k++) bytes_q.push_back(delim_cfg[k*8 +: 8]);
        for (int k = 0; k < bytes_q.size(); k++) begin
            if (k == 0) begin
                send_byte(bytes_q[k], 1'b1, ($urandom_range(0, 9) < 7) ?
                          7'(bytes_q.size()) : 7'($urandom_range(0, 64)));
            end else if ($urandom_range(0, 15) == 0) begin
                send_byte(bytes_q[k], 1'b1, 7'($urandom_range(0, 16)));
            end else begin
                send_byte(bytes_q[k], 1'b0, 7'($urandom_range(0, 64)));
            end
        end
    endtask

    task automatic send_random_line();
        int r;
        int slot;
        int alen;
        r    = $urandom_range(0, 99);
        slot = $urandom_range(0, active_cmd_count() - 1);
        alen = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 54) : $urandom_range(0, 10);
        if (r < 70) begin
            send_command_line(slot, alen, 1'b0);
        end else if (r < 78) begin
            send_command_line($urandom_range(0, 3), alen, 1'b0);
        end else if (r < 90) begin
            send_command_line(slot, alen, 1'b1);
        end else begin
            // Loose bytes with random chunk marks.
            repeat ($urandom_range(1, 12)) begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                          7'($urandom_range(0, 64)));
            end
        end
    endtask

    task automatic randomize_settings(input int phase_no);
        logic [63:0] txt [4];
        logic [15:0] lens;
        logic [2:0]  cnt;
        logic [15:0] dchars;
        logic [1:0]  dlen;
        for (int s = 0; s < 4; s++) txt[s] = {$urandom(), $urandom()};
        case (phase_no)
            0: begin
                lens = 16'hFFFF; cnt = 3'd7; dchars = 16'hFFFF; dlen = 2'd3;
            end
            1: begin
                txt[0] = '0; lens = 16'h0000; cnt = 3'd0; dchars = 16'h0000; dlen = 2'd0;
            end
            default: begin
                for (int s = 0; s < 4; s++) begin
                    lens[s*4 +: 4] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                                 : 4'($urandom_range(1, 8));
                end
                cnt    = 3'($urandom_range(0, 7));
                dchars = 16'($urandom());
                dlen   = 2'($urandom_range(0, 3));
            end
        endcase
        write_all_settings(txt[0], txt[1], txt[2], txt[3], lens, cnt, dchars, dlen);
    endtask

    // Random lines under several settings; the last phase runs without idling.
    task automatic test_random_traffic();
        int first_item;
        int target;
        first_item = sent_items;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            randomize_settings(ph);
            if (ph == RANDOM_PHASES - 1) idle_enable = 1'b0;
            target = first_item + RANDOM_ITEMS * (ph + 1) / RANDOM_PHASES;
            while (sent_items < target) send_random_line();
        end
        drain_results();
    endtask

    // Result receiver with random stall bursts.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_enable && i_rst_n && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_arg_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_args.size() == 0) begin
                report_mismatch($sformatf("result with none pending: cmd %0d byte %02h",
                                          m_axis_tuser[1:0], m_axis_tdata));
            end else begin
                want = expected_args.pop_front();
                if (m_axis_tuser[1:0] !== want.cmd)
                    report_mismatch($sformatf("command index %0d, want %0d",
                                              m_axis_tuser[1:0], want.cmd));
                if (m_axis_tdata !== want.arg)
                    report_mismatch($sformatf("argument byte %02h, want %02h",
                                              m_axis_tdata, want.arg));
                if (m_axis_tuser[2] !== want.arg_ok)
                    report_mismatch($sformatf("argument valid %b, want %b",
                                              m_axis_tuser[2], want.arg_ok));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last %b, want %b", m_axis_tlast, want.last));
            end
        end
    end

    initial begin
        reset_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_command_table();
        test_range_limits();
        test_store_full();
        test_random_traffic();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
